>>> hdl/tlsd_pkg.sv
// Shared types and constants for the two-wire LED strip driver.
package tlsd_pkg;

   // Default depth of the pixel store
   localparam int MAX_PIXELS_DEF = 256;

   // Request codes
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_PIXEL_COUNT = 2'd0;
   localparam logic [1:0] CSR_BRIGHTNESS  = 2'd1;
   localparam logic [1:0] CSR_LATCH_TICKS = 2'd2;

   // Register reset values
   localparam logic [15:0] LATCH_TICKS_RST = 16'd1000;

   // Bits sent per pixel (blue, green, red)
   localparam logic [4:0] BITS_PER_PIXEL = 5'd24;

   // Input word
   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] pixel_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type_type;

   // Result word
   typedef struct packed {
      logic high_line;
      logic low_line;
      logic busy_res;
      logic frame_done;
   } rsp_type_type;

endpackage

>>> hdl/tlsd_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
module tlsd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/two_wire_led_strip_driver_top.sv
// Top level of the two-wire LED strip driver: pixel store, frame sequencer, CSRs.
//
// Usage:
//  - Request channel: a word on req_data is taken when start is high and busy low.
//    req_type selects write pixel, start frame or tick (one half-bit line period).
//  - Every accepted word gives exactly one result word on rsp_data, marked by
//    rsp_valid for one cycle, in the cycle after acceptance. The receiver
//    cannot stall; results must be taken as they appear.
//  - Write and tick words leave busy low, so one may be offered every cycle while
//    busy is low. A start word with pixels to send, and a tick that closes a pixel
//    but the last, raise busy while the next pixel is read and scaled.
//  - CSR channel: csr_ready is always high; a write lands when csr_valid is
//    high. Write registers only while no frame is in progress.
//  - After reset the pixel store is cleared, one entry per cycle, which holds
//    busy high until the sweep ends; CSR writes are still taken meanwhile.
//  - busy_res in a result reports a frame or latch period in progress;
//    frame_done marks the tick that ends the latch period.
module two_wire_led_strip_driver_top #(
   parameter int MAX_PIXELS = tlsd_pkg::MAX_PIXELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  tlsd_pkg::req_type_type req_data,
   // result channel
   output logic                  rsp_valid,
   output tlsd_pkg::rsp_type_type rsp_data,
   // configuration channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_data
);

   localparam int AW   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int IDXW = (AW > 8) ? AW : 8;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PIXELS - 1);

   // Sequencer states
   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_LOAD  = 2'd2;

   // Map a pixel index to a store address
   function automatic logic [AW-1:0] to_addr(input logic [7:0] idx);
      logic [IDXW-1:0] ext;
      ext = IDXW'(idx);
      return ext[AW-1:0];
   endfunction

   // Pixel index lies inside the store
   function automatic logic in_store(input logic [7:0] idx);
      return 32'(idx) < 32'(MAX_PIXELS);
   endfunction

   // Brightness scaling of one channel
   function automatic logic [7:0] scale_chan(input logic [7:0] raw,
                                             input logic [7:0] factor);
      logic [15:0] prod;
      prod = 16'(raw) * 16'(factor);
      return (factor != 8'd0) ? prod[15:8] : raw;
   endfunction

   // Registers
   logic [1:0]           state_ff, state_in;
   logic [AW-1:0]        clr_addr_ff, clr_addr_in;
   logic                 sending_ff, sending_in;
   logic                 latching_ff, latching_in;
   logic [7:0]           pixels_left_ff, pixels_left_in;
   logic [4:0]           bit_counter_ff, bit_counter_in;
   logic                 half_phase_ff, half_phase_in;
   logic [15:0]          latch_counter_ff, latch_counter_in;
   logic [23:0]          shift_word_ff, shift_word_in;
   logic [7:0]           load_idx_ff, load_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   tlsd_pkg::rsp_type_type rsp_data_ff, rsp_data_in;
   logic [7:0]           pixel_count_ff;
   logic [7:0]           brightness_ff;
   logic [15:0]          latch_ticks_ff;

   // Store ports
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [23:0]          mem_wdata;
   logic [23:0]          mem_rdata;

   // Temporaries of the sequencer
   logic                 frame_busy;
   logic [4:0]           bit_next;
   logic [7:0]           left_next;

   tlsd_ram #(
      .WIDTH (24),
      .DEPTH (MAX_PIXELS)
   ) u_pixel_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (to_addr(load_idx_in)),
      .rd_data (mem_rdata)
   );

   // Sequencer next state
   always_comb begin
      state_in         = state_ff;
      clr_addr_in      = clr_addr_ff;
      sending_in       = sending_ff;
      latching_in      = latching_ff;
      pixels_left_in   = pixels_left_ff;
      bit_counter_in   = bit_counter_ff;
      half_phase_in    = half_phase_ff;
      latch_counter_in = latch_counter_ff;
      shift_word_in    = shift_word_ff;
      load_idx_in      = load_idx_ff;
      rsp_valid_in     = 1'b0;
      rsp_data_in      = rsp_data_ff;
      mem_we           = 1'b0;
      mem_waddr        = clr_addr_ff;
      mem_wdata        = 24'd0;
      frame_busy       = sending_ff | latching_ff;
      bit_next         = bit_counter_ff + 5'd1;
      left_next        = pixels_left_ff - 8'd1;

      case (state_ff)
         ST_CLEAR: begin
            // sweep zeros through the store after reset
            mem_we      = 1'b1;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.high_line  = 1'b0;
               rsp_data_in.low_line   = 1'b1;
               rsp_data_in.frame_done = 1'b0;
               case (req_data.req_type)
                  tlsd_pkg::REQ_WRITE: begin
                     if (!frame_busy && req_data.pixel_index < pixel_count_ff &&
                         in_store(req_data.pixel_index)) begin
                        mem_we    = 1'b1;
                        mem_waddr = to_addr(req_data.pixel_index);
                        mem_wdata = {req_data.red, req_data.green, req_data.blue};
                     end
                  end
                  tlsd_pkg::REQ_START: begin
                     if (!frame_busy) begin
                        pixels_left_in = pixel_count_ff;
                        if (pixel_count_ff == 8'd0) begin
                           latching_in      = 1'b1;
                           latch_counter_in = latch_ticks_ff;
                        end else begin
                           sending_in  = 1'b1;
                           load_idx_in = pixel_count_ff - 8'd1;
                           state_in    = ST_LOAD;
                        end
                     end
                  end
                  tlsd_pkg::REQ_TICK: begin
                     if (sending_ff) begin
                        if (!half_phase_ff) begin
                           // first half: data level on both wires
                           rsp_data_in.high_line = shift_word_ff[23];
                           rsp_data_in.low_line  = shift_word_ff[23];
                           half_phase_in         = 1'b1;
                        end else begin
                           // second half: clock level, advance the bit
                           half_phase_in  = 1'b0;
                           shift_word_in  = {shift_word_ff[22:0], 1'b0};
                           bit_counter_in = bit_next;
                           if (bit_next >= tlsd_pkg::BITS_PER_PIXEL) begin
                              pixels_left_in = left_next;
                              if (left_next == 8'd0) begin
                                 sending_in       = 1'b0;
                                 latching_in      = 1'b1;
                                 latch_counter_in = latch_ticks_ff;
                              end else begin
                                 load_idx_in = left_next - 8'd1;
                                 state_in    = ST_LOAD;
                              end
                           end
                        end
                     end else if (latching_ff) begin
                        if (latch_counter_ff <= 16'd1) begin
                           latch_counter_in       = 16'd0;
                           latching_in            = 1'b0;
                           rsp_data_in.frame_done = 1'b1;
                        end else begin
                           latch_counter_in = latch_counter_ff - 16'd1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_data_in.busy_res = sending_in | latching_in;
            end
         end
         ST_LOAD: begin
            // store data is valid now: scale into the shift word
            if (in_store(load_idx_ff)) begin
               shift_word_in = {scale_chan(mem_rdata[7:0], brightness_ff),
                                scale_chan(mem_rdata[15:8], brightness_ff),
                                scale_chan(mem_rdata[23:16], brightness_ff)};
            end else begin
               shift_word_in = 24'd0;
            end
            bit_counter_in = 5'd0;
            half_phase_in  = 1'b0;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_addr_ff      <= '0;
         sending_ff       <= 1'b0;
         latching_ff      <= 1'b0;
         pixels_left_ff   <= 8'd0;
         bit_counter_ff   <= 5'd0;
         half_phase_ff    <= 1'b0;
         latch_counter_ff <= 16'd0;
         shift_word_ff    <= 24'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         clr_addr_ff      <= clr_addr_in;
         sending_ff       <= sending_in;
         latching_ff      <= latching_in;
         pixels_left_ff   <= pixels_left_in;
         bit_counter_ff   <= bit_counter_in;
         half_phase_ff    <= half_phase_in;
         latch_counter_ff <= latch_counter_in;
         shift_word_ff    <= shift_word_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      load_idx_ff <= load_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff <= 8'd0;
         brightness_ff  <= 8'd0;
         latch_ticks_ff <= tlsd_pkg::LATCH_TICKS_RST;
      end else if (csr_valid) begin
         case (csr_index)
            tlsd_pkg::CSR_PIXEL_COUNT: pixel_count_ff <= csr_data[7:0];
            tlsd_pkg::CSR_BRIGHTNESS:  brightness_ff  <= csr_data[7:0];
            tlsd_pkg::CSR_LATCH_TICKS: latch_ticks_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
